// ===== src/assert_macros.svh =====
// Assertion macros shared by the session table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/dst_pkg.sv =====
// -----------------------------------------------------------------------------
// dst_pkg
// Types and constants of the session table with replay window.
// -----------------------------------------------------------------------------
package dst_pkg;

   typedef enum logic [2:0] {
      OP_CREATE     = 3'd0,
      OP_DELETE     = 3'd1,
      OP_EPOCH      = 3'd2,
      OP_NEXT_WSEQ  = 3'd3,
      OP_CHECK_RSEQ = 3'd4,
      OP_KEY_LOOKUP = 3'd5,
      OP_KEY_INSERT = 3'd6,
      OP_NONE       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_REPLAY    = 3'd3,
      ST_NO_KEY    = 3'd4
   } status_type;

   typedef enum logic {
      CSR_WIN_BELOW = 1'b0,
      CSR_WIN_ABOVE = 1'b1
   } csr_index_type;

   localparam int ADDR_W   = 64;
   localparam int SEQ_W    = 32;
   localparam int EPOCH_W  = 16;
   localparam int SLOT_W   = 3;
   localparam int KSLOT_W  = 4;
   localparam int BELOW_W  = 8;
   localparam int ABOVE_W  = 16;
   localparam int CSR_W    = 16;

   localparam logic [BELOW_W-1:0] WIN_BELOW_RST = 8'd10;
   localparam logic [ABOVE_W-1:0] WIN_ABOVE_RST = 16'd100;
   localparam logic [SEQ_W-1:0]   SEQ_START     = 32'd1;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [SEQ_W-1:0]   rseq;
      logic [SEQ_W-1:0]   wseq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic cmp;
      logic sel;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic drop;
      logic out_free;
   } stat_type;

endpackage

// ===== src/dst_ifs.sv =====
// -----------------------------------------------------------------------------
// dst_ifs
// Request, response and register-write channels of the session table.
// -----------------------------------------------------------------------------
interface dst_req_if;
   import dst_pkg::*;
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [ADDR_W-1:0]    addr_high;
   logic [ADDR_W-1:0]    addr_low;
   logic [SEQ_W-1:0]     recv_seq;
   logic [EPOCH_W-1:0]   req_epoch;
   logic                 advance;
   modport source (output valid, op, addr_high, addr_low, recv_seq, req_epoch, advance,
                   input ready);
   modport sink   (input valid, op, addr_high, addr_low, recv_seq, req_epoch, advance,
                   output ready);
endinterface

interface dst_rsp_if;
   import dst_pkg::*;
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SLOT_W-1:0]    slot;
   logic [EPOCH_W-1:0]   epoch_out;
   logic [SEQ_W-1:0]     seq_out;
   logic [KSLOT_W-1:0]   key_slot;
   logic                 promote_key;
   modport source (output valid, status, slot, epoch_out, seq_out, key_slot, promote_key,
                   input ready);
   modport sink   (input valid, status, slot, epoch_out, seq_out, key_slot, promote_key,
                   output ready);
endinterface

interface dst_csr_if;
   import dst_pkg::*;
   logic                 valid;
   logic                 ready;
   csr_index_type        index;
   logic [CSR_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dst_ram.sv =====
// -----------------------------------------------------------------------------
// dst_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module dst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

// ===== src/dst_ctrl.sv =====
// -----------------------------------------------------------------------------
// dst_ctrl
// Sequencer: take a request, compare, select the entry, execute and respond.
// -----------------------------------------------------------------------------
module dst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dst_pkg::stat_type st,
   output dst_pkg::cmd_type  cmd
);
   import dst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SEL  = 4'b0100,
      S_EXEC = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // no-operation opcode: drop without a response
               if (!st.drop) state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (st.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ===== src/dst_dp.sv =====
// -----------------------------------------------------------------------------
// dst_dp
// Datapath: address match, entry RAM, window check and response register.
// -----------------------------------------------------------------------------
module dst_dp #(
   parameter int SESSIONS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dst_pkg::cmd_type              cmd,
   output dst_pkg::stat_type             st,
   // request payload
   input  dst_pkg::op_type               req_op,
   input  logic [dst_pkg::ADDR_W-1:0]    req_addr_high,
   input  logic [dst_pkg::ADDR_W-1:0]    req_addr_low,
   input  logic [dst_pkg::SEQ_W-1:0]     req_recv_seq,
   input  logic [dst_pkg::EPOCH_W-1:0]   req_req_epoch,
   input  logic                          req_advance,
   // register writes
   input  logic                          csr_we,
   input  dst_pkg::csr_index_type        csr_index,
   input  logic [dst_pkg::CSR_W-1:0]     csr_data,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dst_pkg::status_type           rsp_status,
   output logic [dst_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [dst_pkg::EPOCH_W-1:0]   rsp_epoch_out,
   output logic [dst_pkg::SEQ_W-1:0]     rsp_seq_out,
   output logic [dst_pkg::KSLOT_W-1:0]   rsp_key_slot,
   output logic                          rsp_promote_key
);
   import dst_pkg::*;

   localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

   // request hold
   op_type              op_ff;
   logic [ADDR_W-1:0]   ahi_ff, alo_ff;
   logic [SEQ_W-1:0]    recv_ff;
   logic [EPOCH_W-1:0]  repoch_ff;
   logic                adv_ff;

   // table
   logic [SESSIONS-1:0] valid_ff;
   logic [ADDR_W-1:0]   peer_hi_ff [SESSIONS];
   logic [ADDR_W-1:0]   peer_lo_ff [SESSIONS];
   logic [SESSIONS-1:0] hit_ff, free_ff;

   logic [IDX_W-1:0]    idx_ff, idx_in, hit_idx, free_idx;
   logic                found_ff, has_free_ff;

   logic [BELOW_W-1:0]  win_below_ff;
   logic [ABOVE_W-1:0]  win_above_ff;

   // response register
   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [KSLOT_W-1:0]  kslot_ff, kslot_in;
   logic                prom_ff, prom_in;

   // RAM side
   entry_type           ent, wr_ent;
   logic                ram_we;
   logic [IDX_W-1:0]    raddr;
   logic                set_valid, clr_valid;

   logic [IDX_W+2:0]    idx_ext;
   logic [IDX_W+3:0]    ks_cur, ks_pend;
   logic [SEQ_W-1:0]    seq_diff, shifted, span;
   logic [EPOCH_W-1:0]  req_m1, ep_new;

   assign st.drop     = (req_op == OP_NONE);
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   // priority pick of lowest matching and lowest free entry
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = SESSIONS - 1; i >= 0; i--) begin
         if (hit_ff[i])  hit_idx  = IDX_W'(i);
         if (free_ff[i]) free_idx = IDX_W'(i);
      end
      idx_in = (|hit_ff) ? hit_idx : free_idx;
   end

   assign raddr = cmd.sel ? idx_in : idx_ff;

   dst_ram #(.WIDTH(ENTRY_W), .DEPTH(SESSIONS)) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (idx_ff),
      .wdata    (wr_ent),
      .raddr    (raddr),
      .rdata_ff (ent)
   );

   always_comb begin
      idx_ext   = {3'b000, idx_ff};
      ks_cur    = {idx_ext, 1'b0};
      ks_pend   = {idx_ext, 1'b1};
      seq_diff  = recv_ff - ent.rseq;
      shifted   = seq_diff + SEQ_W'(win_below_ff);
      span      = SEQ_W'(win_below_ff) + SEQ_W'(win_above_ff);
      req_m1    = repoch_ff - EPOCH_W'(1);
      ep_new    = ent.epoch;

      status_in = ST_OK;
      slot_in   = '0;
      epoch_in  = '0;
      seq_in    = '0;
      kslot_in  = '0;
      prom_in   = 1'b0;
      ram_we    = 1'b0;
      wr_ent    = ent;
      set_valid = 1'b0;
      clr_valid = 1'b0;

      case (op_ff)
         OP_CREATE: begin
            if (found_ff) begin
               slot_in  = idx_ext[SLOT_W-1:0];
               epoch_in = ent.epoch;
            end else if (has_free_ff) begin
               ram_we    = 1'b1;
               wr_ent    = '{epoch: '0, rseq: SEQ_START, wseq: SEQ_START};
               set_valid = 1'b1;
               slot_in   = idx_ext[SLOT_W-1:0];
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_DELETE, OP_EPOCH, OP_KEY_INSERT: begin
            if (found_ff) begin
               clr_valid = (op_ff == OP_DELETE);
               slot_in   = idx_ext[SLOT_W-1:0];
               epoch_in  = ent.epoch;
               if (op_ff == OP_KEY_INSERT) kslot_in = ks_pend[KSLOT_W-1:0];
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_NEXT_WSEQ: begin
            if (found_ff) begin
               seq_in      = ent.wseq;
               ram_we      = 1'b1;
               wr_ent.wseq = ent.wseq + SEQ_W'(1);
               slot_in     = idx_ext[SLOT_W-1:0];
               epoch_in    = ent.epoch;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_CHECK_RSEQ: begin
            // no session: accept silently
            if (found_ff) begin
               slot_in  = idx_ext[SLOT_W-1:0];
               epoch_in = ent.epoch;
               if (shifted > span) begin
                  status_in = ST_REPLAY;
               end else begin
                  ram_we      = 1'b1;
                  wr_ent.rseq = recv_ff + SEQ_W'(1);
               end
            end
         end
         OP_KEY_LOOKUP: begin
            if (repoch_ff == '0) begin
               status_in = ST_NO_KEY;
            end else if (!found_ff) begin
               status_in = ST_NOT_FOUND;
            end else begin
               // advance the epoch and restart both sequence numbers
               if (adv_ff && ent.epoch == req_m1) begin
                  ep_new  = repoch_ff;
                  ram_we  = 1'b1;
                  wr_ent  = '{epoch: repoch_ff, rseq: SEQ_START, wseq: SEQ_START};
                  prom_in = 1'b1;
               end
               if (ep_new == repoch_ff)   kslot_in  = ks_cur[KSLOT_W-1:0];
               else if (ep_new == req_m1) kslot_in  = ks_pend[KSLOT_W-1:0];
               else                       status_in = ST_NO_KEY;
               slot_in  = idx_ext[SLOT_W-1:0];
               epoch_in = ep_new;
            end
         end
         default: status_in = ST_OK;
      endcase
      ram_we    = ram_we && cmd.commit;
      set_valid = set_valid && cmd.commit;
      clr_valid = clr_valid && cmd.commit;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         ahi_ff    <= req_addr_high;
         alo_ff    <= req_addr_low;
         recv_ff   <= req_recv_seq;
         repoch_ff <= req_req_epoch;
         adv_ff    <= req_advance;
      end
      if (cmd.cmp) begin
         for (int i = 0; i < SESSIONS; i++) begin
            hit_ff[i]  <= valid_ff[i] && peer_hi_ff[i] == ahi_ff && peer_lo_ff[i] == alo_ff;
            free_ff[i] <= !valid_ff[i];
         end
      end
      if (cmd.sel) begin
         idx_ff      <= idx_in;
         found_ff    <= |hit_ff;
         has_free_ff <= |free_ff;
      end
      if (set_valid) begin
         peer_hi_ff[idx_ff] <= ahi_ff;
         peer_lo_ff[idx_ff] <= alo_ff;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         epoch_ff  <= epoch_in;
         seq_ff    <= seq_in;
         kslot_ff  <= kslot_in;
         prom_ff   <= prom_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         win_below_ff <= WIN_BELOW_RST;
         win_above_ff <= WIN_ABOVE_RST;
      end else begin
         if (set_valid) valid_ff[idx_ff] <= 1'b1;
         if (clr_valid) valid_ff[idx_ff] <= 1'b0;
         if (cmd.commit)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_WIN_BELOW: win_below_ff <= csr_data[BELOW_W-1:0];
               CSR_WIN_ABOVE: win_above_ff <= csr_data[ABOVE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_epoch_out   = epoch_ff;
   assign rsp_seq_out     = seq_ff;
   assign rsp_key_slot    = kslot_ff;
   assign rsp_promote_key = prom_ff;
endmodule

// ===== src/dtls_session_table_core.sv =====
// -----------------------------------------------------------------------------
// dtls_session_table_core
// Session table with per-peer epoch, sequence numbers and replay window.
// -----------------------------------------------------------------------------
// One request transaction yields one response transaction (opcode seven is
// taken and dropped). A request passes through the sequencer in these steps:
// register the request, compare the peer address against every entry in
// parallel, pick the lowest matching (or lowest free) slot while the entry RAM
// is read, then execute the read-modify-write and load the response register.
// A response that is not taken holds the execute step and stalls the input.
// The next request is taken as soon as the sequencer is back in idle, also
// while the previous response still waits; no new request is taken while the
// sequencer works on the previous one. Window registers are written through
// the csr channel, which is always ready.
`include "assert_macros.svh"

module dtls_session_table_core #(
   parameter int SESSIONS = 8
) (
   input  logic       clock,
   input  logic       reset,
   dst_req_if.sink    req,
   dst_rsp_if.source  rsp,
   dst_csr_if.sink    csr
);
   import dst_pkg::*;

   cmd_type  cmd;
   stat_type st;
   logic     req_ready;

   assign req.ready = req_ready;
   assign csr.ready = 1'b1;

   // sequencer
   dst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // table, window check and response hold
   dst_dp #(.SESSIONS(SESSIONS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_op          (req.op),
      .req_addr_high   (req.addr_high),
      .req_addr_low    (req.addr_low),
      .req_recv_seq    (req.recv_seq),
      .req_req_epoch   (req.req_epoch),
      .req_advance     (req.advance),
      .csr_we          (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_status      (rsp.status),
      .rsp_slot        (rsp.slot),
      .rsp_epoch_out   (rsp.epoch_out),
      .rsp_seq_out     (rsp.seq_out),
      .rsp_key_slot    (rsp.key_slot),
      .rsp_promote_key (rsp.promote_key)
   );

   // never overwrite a response that has not been taken
   `ASSERT_IMPLY(a_commit_free, clock, reset, cmd.commit, (!rsp.valid || rsp.ready))
   // a real request blocks the input until it is executed
   `ASSERT_NEXT(a_busy_after_take, clock, reset, (req.valid && req.ready && !st.drop), !req.ready)
   // the sequencer issues at most one command per cycle
   `ASSERT_IMPLY(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.cmp, cmd.sel, cmd.commit}))
endmodule
